/* rtl/aci_pkg.sv */
// Shared types, character codes and the digit table for the ASCII command interpreter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package aci_pkg;

  // ASCII codes of command letters, reply characters and digits
  localparam logic [7:0] ChL = 8'h4C;
  localparam logic [7:0] ChS = 8'h53;
  localparam logic [7:0] ChB = 8'h42;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChH = 8'h48;
  localparam logic [7:0] ChP = 8'h50;
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] ChE = 8'h45;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChK = 8'h4B;
  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChR = 8'h52;
  localparam logic [7:0] Ch0 = 8'h30;
  localparam logic [7:0] Ch1 = 8'h31;
  localparam logic [7:0] Ch9 = 8'h39;

  // Widths of the decimal argument and the LED mask
  localparam int unsigned ValueW = 14;
  localparam int unsigned MaskW  = 4;
  localparam logic [ValueW-1:0] ValueMax = 14'd9999;

  // Run queue between parser and emitter
  localparam int unsigned QueueAw    = 1;
  localparam int unsigned QueueDepth = 1 << QueueAw;

  typedef enum logic [4:0] {
    ST_IDLE, ST_L, ST_LS, ST_LC, ST_S,
    ST_B0, ST_B1, ST_B2,
    ST_H0, ST_H1, ST_H2,
    ST_C0, ST_C1, ST_C2,
    ST_P0, ST_P1, ST_P2, ST_P3,
    ST_I0, ST_I1, ST_I2, ST_I3,
    ST_D0, ST_D1, ST_D2, ST_D3
  } parser_state_e;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_LED, ACT_BUZZER, ACT_HEATER, ACT_REF, ACT_PGAIN, ACT_IGAIN, ACT_DGAIN
  } action_e;

  // Reply shape: ACK, ERR, or ACK followed by a switch reading
  typedef enum logic [1:0] {
    RUN_ACK, RUN_ERR, RUN_ACK_SW
  } run_kind_e;

  // One reply run handed from the parser to the emitter
  typedef struct packed {
    run_kind_e         kind;
    action_e           action;
    logic [ValueW-1:0] value;
    logic [MaskW-1:0]  led;
    logic              closed;
  } aci_run_t;

  typedef struct packed {
    logic          is_digit_st;
    action_e       action;
    logic [9:0]    weight;
    logic          last_digit;
    parser_state_e next_st;
  } digit_info_t;

  // Digit states: action, decimal weight and successor
  function automatic digit_info_t digit_info(input parser_state_e st);
    digit_info_t di;
    di = '{is_digit_st: 1'b1, action: ACT_NONE, weight: 10'd0,
           last_digit: 1'b0, next_st: ST_IDLE};
    unique case (st)
      ST_B0: begin di.action = ACT_BUZZER; di.weight = 10'd100;  di.next_st = ST_B1; end
      ST_B1: begin di.action = ACT_BUZZER; di.weight = 10'd10;   di.next_st = ST_B2; end
      ST_B2: begin di.action = ACT_BUZZER; di.weight = 10'd1;    di.last_digit = 1'b1; end
      ST_H0: begin di.action = ACT_HEATER; di.weight = 10'd100;  di.next_st = ST_H1; end
      ST_H1: begin di.action = ACT_HEATER; di.weight = 10'd10;   di.next_st = ST_H2; end
      ST_H2: begin di.action = ACT_HEATER; di.weight = 10'd1;    di.last_digit = 1'b1; end
      ST_C0: begin di.action = ACT_REF;    di.weight = 10'd100;  di.next_st = ST_C1; end
      ST_C1: begin di.action = ACT_REF;    di.weight = 10'd10;   di.next_st = ST_C2; end
      ST_C2: begin di.action = ACT_REF;    di.weight = 10'd1;    di.last_digit = 1'b1; end
      ST_P0: begin di.action = ACT_PGAIN;  di.weight = 10'd1000; di.next_st = ST_P1; end
      ST_P1: begin di.action = ACT_PGAIN;  di.weight = 10'd100;  di.next_st = ST_P2; end
      ST_P2: begin di.action = ACT_PGAIN;  di.weight = 10'd10;   di.next_st = ST_P3; end
      ST_P3: begin di.action = ACT_PGAIN;  di.weight = 10'd1;    di.last_digit = 1'b1; end
      ST_I0: begin di.action = ACT_IGAIN;  di.weight = 10'd1000; di.next_st = ST_I1; end
      ST_I1: begin di.action = ACT_IGAIN;  di.weight = 10'd100;  di.next_st = ST_I2; end
      ST_I2: begin di.action = ACT_IGAIN;  di.weight = 10'd10;   di.next_st = ST_I3; end
      ST_I3: begin di.action = ACT_IGAIN;  di.weight = 10'd1;    di.last_digit = 1'b1; end
      ST_D0: begin di.action = ACT_DGAIN;  di.weight = 10'd1000; di.next_st = ST_D1; end
      ST_D1: begin di.action = ACT_DGAIN;  di.weight = 10'd100;  di.next_st = ST_D2; end
      ST_D2: begin di.action = ACT_DGAIN;  di.weight = 10'd10;   di.next_st = ST_D3; end
      ST_D3: begin di.action = ACT_DGAIN;  di.weight = 10'd1;    di.last_digit = 1'b1; end
      default: di.is_digit_st = 1'b0;
    endcase
    return di;
  endfunction

endpackage

/* rtl/aci_parser.sv */
// Front end: parses one received byte per accepted request and builds reply runs.
// Depends on aci_pkg.
`timescale 1ns / 1ps

module aci_parser #(
  parameter int unsigned NUM_LEDS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              rx_byte_i,
  input  logic [3:0]              switch_levels_i,
  output logic                    run_valid_o,
  output aci_pkg::aci_run_t       run_o
);
  import aci_pkg::*;

  localparam logic [7:0] UnitMax = 8'(48 + NUM_LEDS);

  parser_state_e     state_q, state_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [MaskW-1:0]  led_q, led_d;

  logic              is_digit, is_unit, in_mask;
  logic [3:0]        digit;
  logic [1:0]        unit_idx;
  logic [MaskW-1:0]  led_bit;
  logic [ValueW-1:0] prod;
  logic [ValueW:0]   sum;
  logic [ValueW-1:0] acc_sat;
  digit_info_t       di;

  // Classify the byte
  always_comb begin
    is_digit = (rx_byte_i >= Ch0) && (rx_byte_i <= Ch9);
    is_unit  = (rx_byte_i >= Ch1) && (rx_byte_i <= UnitMax);
    digit    = rx_byte_i[3:0];
    in_mask  = is_unit && (digit <= 4'd4);
    unit_idx = 2'(digit - 4'd1);
    led_bit  = MaskW'(1) << unit_idx;
    di       = digit_info(state_q);
    prod     = ValueW'(digit) * ValueW'(di.weight);
    sum      = (ValueW+1)'(acc_q) + (ValueW+1)'(prod);
    acc_sat  = (sum > (ValueW+1)'(ValueMax)) ? ValueMax : sum[ValueW-1:0];
  end

  // Next parser state and reply run
  always_comb begin
    state_d      = ST_IDLE;
    acc_d        = acc_q;
    led_d        = led_q;
    run_valid_o  = 1'b0;
    run_o.kind   = RUN_ERR;
    run_o.action = ACT_NONE;
    run_o.value  = '0;
    run_o.closed = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        acc_d = '0;
        unique case (rx_byte_i)
          ChL:     state_d = ST_L;
          ChS:     state_d = ST_S;
          ChB:     state_d = ST_B0;
          ChC:     state_d = ST_C0;
          ChH:     state_d = ST_H0;
          ChP:     state_d = ST_P0;
          ChI:     state_d = ST_I0;
          ChD:     state_d = ST_D0;
          default: run_valid_o = 1'b1;
        endcase
      end
      ST_L: begin
        // anything but S or C drops back silently
        if (rx_byte_i == ChS) begin
          state_d = ST_LS;
        end else if (rx_byte_i == ChC) begin
          state_d = ST_LC;
        end
      end
      ST_LS, ST_LC: begin
        run_valid_o = 1'b1;
        if (is_unit) begin
          run_o.kind   = RUN_ACK;
          run_o.action = ACT_LED;
          if (in_mask) begin
            led_d = (state_q == ST_LS) ? (led_q | led_bit) : (led_q & ~led_bit);
          end
        end
      end
      ST_S: begin
        run_valid_o = 1'b1;
        if (is_unit) begin
          run_o.kind   = RUN_ACK_SW;
          run_o.closed = in_mask && switch_levels_i[unit_idx];
        end
      end
      default: begin
        if (di.is_digit_st) begin
          if (is_digit) begin
            acc_d = acc_sat;
            if (di.last_digit) begin
              run_valid_o  = 1'b1;
              run_o.kind   = RUN_ACK;
              run_o.action = di.action;
              run_o.value  = acc_sat;
              acc_d        = '0;
            end else begin
              state_d = di.next_st;
            end
          end else begin
            run_valid_o = 1'b1;
            acc_d       = '0;
          end
        end
      end
    endcase
    run_o.led = led_d;
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      led_q   <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
      acc_q   <= acc_d;
      led_q   <= led_d;
    end
  end

endmodule

/* rtl/aci_fifo.sv */
// Short queue of reply runs between parser and emitter.
// Depends on aci_pkg.
`timescale 1ns / 1ps

module aci_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  aci_pkg::aci_run_t push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output aci_pkg::aci_run_t head_o
);
  import aci_pkg::*;

  aci_run_t           entry_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q;

  assign full_o  = (count_q == (QueueAw+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Store pushed runs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/aci_emitter.sv */
// Back end: expands each queued run into reply characters, one per output request.
// Depends on aci_pkg.
`timescale 1ns / 1ps

module aci_emitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              run_avail_i,
  input  aci_pkg::aci_run_t run_i,
  output logic              run_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        tx_byte_o,
  output aci_pkg::action_e  action_o,
  output logic [13:0]       action_value_o,
  output logic [3:0]        led_mask_o,
  output logic              last_o
);
  import aci_pkg::*;

  logic [1:0]        idx_q;
  logic              valid_q;
  logic [7:0]        byte_q;
  action_e           action_q;
  logic [ValueW-1:0] value_q;
  logic [MaskW-1:0]  led_q;
  logic              last_q;

  logic              load;
  logic [7:0]        ch;
  logic              is_last;

  assign load      = run_avail_i && (!valid_q || out_ready_i);
  assign run_pop_o = load && is_last;

  // Pick the character for the current position in the run
  always_comb begin
    ch      = ChE;
    is_last = (idx_q == 2'd2);
    unique case (run_i.kind)
      RUN_ERR: ch = (idx_q == 2'd0) ? ChE : ChR;
      RUN_ACK, RUN_ACK_SW: begin
        unique case (idx_q)
          2'd0: ch = ChA;
          2'd1: ch = ChC;
          2'd2: ch = ChK;
          2'd3: ch = run_i.closed ? ChC : ChO;
          default: ch = ChA;
        endcase
        if (run_i.kind == RUN_ACK_SW) begin
          is_last = (idx_q == 2'd3);
        end
      end
      default: ch = ChE;
    endcase
  end

  // Step through the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the output payload until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= ch;
      action_q <= (idx_q == 2'd0) ? run_i.action : ACT_NONE;
      value_q  <= (idx_q == 2'd0) ? run_i.value : '0;
      led_q    <= run_i.led;
      last_q   <= is_last;
    end
  end

  assign out_valid_o    = valid_q;
  assign tx_byte_o      = byte_q;
  assign action_o       = action_q;
  assign action_value_o = value_q;
  assign led_mask_o     = led_q;
  assign last_o         = last_q;

endmodule

/* rtl/ascii_command_interpreter.sv */
// Top level of the ASCII command interpreter: parser, run queue and reply emitter.
// Depends on aci_pkg, aci_parser, aci_fifo and aci_emitter.
//
//   Channel  Dir  Handshake             Payload
//   s_axis   in   tvalid/tready         tdata[7:0] rx_byte, [11:8] switch_levels
//   m_axis   out  tvalid/tready/tlast   tdata[0] tx_valid, [8:1] tx_byte, [11:9] action,
//                                       [25:12] action_value, [29:26] led_mask
//
// A byte is parsed in the cycle it is accepted.
// A byte that completes a command or is rejected queues one run, which the emitter sends
// as 3 or 4 results, one per cycle while the output is ready.
// The first result of a run is registered in the run queue and then in the output register.
// The two-entry run queue keeps input accepted while the output is stalled; a run stays
// queued until its last result is loaded, so input stalls when two runs are held, the
// one being sent counting as one. Reset clears the parser to idle, the digit
// accumulator and the LED pattern, empties the queue and drops the output register.
`timescale 1ns / 1ps

module ascii_command_interpreter #(
  parameter int unsigned NUM_LEDS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [11:8] switch_levels, [15:12] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] tx_valid, [8:1] tx_byte, [11:9] action,
                                      // [25:12] action_value, [29:26] led_mask, [31:30] zero
  output logic        m_axis_tlast
);
  import aci_pkg::*;

  logic              accept;
  logic              run_valid, full, empty, pop;
  aci_run_t          run, head;
  logic [7:0]        tx_byte;
  action_e           action;
  logic [ValueW-1:0] action_value;
  logic [MaskW-1:0]  led_mask;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Parse incoming bytes
  aci_parser #(
    .NUM_LEDS(NUM_LEDS)
  ) u_parser (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .rx_byte_i      (s_axis_tdata[7:0]),
    .switch_levels_i(s_axis_tdata[11:8]),
    .run_valid_o    (run_valid),
    .run_o          (run)
  );

  // Queue reply runs
  aci_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i     (accept && run_valid),
    .push_data_i(run),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head)
  );

  // Send reply characters
  aci_emitter u_emitter (
    .clk_i,
    .rst_ni,
    .run_avail_i   (!empty),
    .run_i         (head),
    .run_pop_o     (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .tx_byte_o     (tx_byte),
    .action_o      (action),
    .action_value_o(action_value),
    .led_mask_o    (led_mask),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, led_mask, action_value, action, tx_byte, 1'b1};

endmodule

/* rtl/aci_checker.sv */
// Port-level checks on the reply stream of the ASCII command interpreter.
// Depends on aci_pkg; bound to ascii_command_interpreter below.
`timescale 1ns / 1ps

module aci_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import aci_pkg::*;

  logic       mid_run_q;
  logic [3:0] run_led_q;
  logic       out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Track whether a run is in progress and its LED mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_run_q <= 1'b0;
      run_led_q <= '0;
    end else if (out_acc) begin
      mid_run_q <= !m_axis_tlast;
      run_led_q <= m_axis_tdata[29:26];
    end
  end

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_tx_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0])
    else $error("tx_valid low on a result");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !mid_run_q |-> (m_axis_tdata[8:1] == ChA) || (m_axis_tdata[8:1] == ChE))
    else $error("run does not start with A or E");

  a_action_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mid_run_q |-> (m_axis_tdata[11:9] == 3'd0) && (m_axis_tdata[25:12] == '0))
    else $error("action given after the first result of a run");

  a_led_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mid_run_q |-> m_axis_tdata[29:26] == run_led_q)
    else $error("LED mask changed within a run");

endmodule

bind ascii_command_interpreter aci_checker u_aci_checker (.*);

/* tb/aci_reply_checker.sv */
// Reply checker for the ASCII command interpreter: watches both streams, parses every
// accepted request byte itself and compares each reply character. Depends on aci_pkg.
`timescale 1ns / 1ps

module aci_reply_checker #(
  parameter int unsigned NumLeds = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [15:0] s_data_i,    // [7:0] rx_byte, [11:8] switch_levels
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,    // [0] tx_valid, [8:1] tx_byte, [11:9] action,
                                   // [25:12] action_value, [29:26] led_mask
  input  logic        m_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import aci_pkg::*;

  // One reply character with its side fields
  typedef struct packed {
    logic              txv;
    logic [7:0]        ch;
    action_e           act;
    logic [ValueW-1:0] val;
    logic [MaskW-1:0]  mask;
    logic              last;
  } reply_t;

  // Shadow copy of the parser
  parser_state_e     cmd_state;
  logic [ValueW-1:0] digit_sum;
  logic [MaskW-1:0]  led_state;

  reply_t expected_replies[$];
  reply_t run_replies[$];
  int     fail_count;

  function automatic void add_reply(logic [7:0] ch, action_e act, logic [ValueW-1:0] val);
    reply_t r;
    r = '{txv: 1'b1, ch: ch, act: act, val: val, mask: '0, last: 1'b0};
    run_replies.push_back(r);
  endfunction

  function automatic void add_ack(action_e act, logic [ValueW-1:0] val);
    add_reply(ChA, act, val);
    add_reply(ChC, ACT_NONE, '0);
    add_reply(ChK, ACT_NONE, '0);
  endfunction

  function automatic void add_err();
    add_reply(ChE, ACT_NONE, '0);
    add_reply(ChR, ACT_NONE, '0);
    add_reply(ChR, ACT_NONE, '0);
  endfunction

  // Decimal weight of the digit taken in a digit state
  function automatic int unsigned place_weight(parser_state_e st);
    case (st)
      ST_P0, ST_I0, ST_D0:                      return 1000;
      ST_B0, ST_H0, ST_C0, ST_P1, ST_I1, ST_D1: return 100;
      ST_B1, ST_H1, ST_C1, ST_P2, ST_I2, ST_D2: return 10;
      default:                                  return 1;
    endcase
  endfunction

  function automatic action_e digit_action(parser_state_e st);
    case (st)
      ST_B0, ST_B1, ST_B2:        return ACT_BUZZER;
      ST_H0, ST_H1, ST_H2:        return ACT_HEATER;
      ST_C0, ST_C1, ST_C2:        return ACT_REF;
      ST_P0, ST_P1, ST_P2, ST_P3: return ACT_PGAIN;
      ST_I0, ST_I1, ST_I2, ST_I3: return ACT_IGAIN;
      default:                    return ACT_DGAIN;
    endcase
  endfunction

  function automatic logic is_last_place(parser_state_e st);
    case (st)
      ST_B2, ST_H2, ST_C2, ST_P3, ST_I3, ST_D3: return 1'b1;
      default:                                  return 1'b0;
    endcase
  endfunction

  // Advance the shadow parser by one byte and queue the replies it causes
  task automatic parse_byte(input logic [7:0] b, input logic [3:0] sw);
    logic             is_num;
    logic             is_unit;
    int unsigned      d;
    int unsigned      sum;
    parser_state_e    st;
    logic             closed;
    logic [MaskW-1:0] led_bit;
    is_num  = (b >= Ch0) && (b <= Ch9);
    d       = is_num ? int'(b - Ch0) : 0;
    is_unit = (b >= Ch1) && (b <= Ch0 + NumLeds);
    st      = cmd_state;
    cmd_state = ST_IDLE;
    run_replies.delete();
    case (st)
      ST_IDLE: begin
        case (b)
          ChL:     cmd_state = ST_L;
          ChS:     cmd_state = ST_S;
          ChB:     cmd_state = ST_B0;
          ChC:     cmd_state = ST_C0;
          ChH:     cmd_state = ST_H0;
          ChP:     cmd_state = ST_P0;
          ChI:     cmd_state = ST_I0;
          ChD:     cmd_state = ST_D0;
          default: add_err();
        endcase
        digit_sum = '0;
      end
      // anything but S or C after L drops back to idle without a reply
      ST_L: begin
        if (b == ChS) cmd_state = ST_LS;
        else if (b == ChC) cmd_state = ST_LC;
      end
      ST_LS, ST_LC: begin
        if (is_unit) begin
          // an LED beyond the mask width is accepted but changes nothing
          if (d <= MaskW) begin
            led_bit = '0;
            led_bit[d-1] = 1'b1;
            if (st == ST_LS) led_state = led_state | led_bit;
            else led_state = led_state & ~led_bit;
          end
          add_ack(ACT_LED, '0);
        end else begin
          add_err();
        end
      end
      ST_S: begin
        if (is_unit) begin
          closed = (d <= 4) && sw[d-1];
          add_ack(ACT_NONE, '0);
          add_reply(closed ? ChC : ChO, ACT_NONE, '0);
        end else begin
          add_err();
        end
      end
      default: begin
        if (is_num) begin
          sum = digit_sum + d * place_weight(st);
          if (sum > ValueMax) sum = ValueMax;
          digit_sum = sum[ValueW-1:0];
          if (is_last_place(st)) begin
            add_ack(digit_action(st), digit_sum);
            digit_sum = '0;
          end else begin
            cmd_state = parser_state_e'(st + 5'd1);
          end
        end else begin
          add_err();
          digit_sum = '0;
        end
      end
    endcase
    // stamp the final LED mask on each reply and mark the end of the run
    foreach (run_replies[k]) begin
      run_replies[k].mask = led_state;
      run_replies[k].last = (k == run_replies.size() - 1);
      expected_replies.push_back(run_replies[k]);
    end
  endtask

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Sample both channels at each edge: predict from requests, check replies
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      cmd_state = ST_IDLE;
      digit_sum = '0;
      led_state = '0;
      expected_replies.delete();
      fail_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i) parse_byte(s_data_i[7:0], s_data_i[11:8]);
      if (m_valid_i && m_ready_i) begin
        got = '{txv: m_data_i[0], ch: m_data_i[8:1], act: action_e'(m_data_i[11:9]),
                val: m_data_i[25:12], mask: m_data_i[29:26], last: m_last_i};
        if (expected_replies.size() == 0) begin
          note_failure($sformatf("unexpected reply ch=%h act=%0d val=%0d mask=%h last=%b",
                                 got.ch, got.act, got.val, got.mask, got.last));
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            note_failure($sformatf({"reply mismatch: expected txv=%b ch=%h act=%0d val=%0d ",
                                    "mask=%h last=%b, got txv=%b ch=%h act=%0d val=%0d ",
                                    "mask=%h last=%b"},
                                   want.txv, want.ch, want.act, want.val, want.mask,
                                   want.last, got.txv, got.ch, got.act, got.val,
                                   got.mask, got.last));
          end
        end
      end
      fail_count_o <= fail_count;
      pending_o <= expected_replies.size();
    end
  end

endmodule

/* tb/ascii_command_interpreter_test.sv */
// Top of the ASCII command interpreter testbench: clock, reset, request and reply drivers.
// Depends on aci_pkg, ascii_command_interpreter and aci_reply_checker.
`timescale 1ns / 1ps

module ascii_command_interpreter_test;
  import aci_pkg::*;

  localparam int unsigned NumLeds = 4;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data  = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned bytes_sent     = 0;
  logic [7:0]  cmd_bytes[$];

  always #5 clk_i = ~clk_i;

  ascii_command_interpreter #(
    .NUM_LEDS(NumLeds)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  aci_reply_checker #(
    .NumLeds(NumLeds)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_data),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_axis_tdata),
    .m_last_i    (m_axis_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Offer one request byte and hold it until it is taken
  task automatic send_byte(input logic [7:0] b, input logic [3:0] sw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {4'b0000, sw, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_all();
    while (cmd_bytes.size() > 0) send_byte(cmd_bytes.pop_front(), 4'($urandom_range(15)));
  endtask

  // Digits lean toward the extremes 0 and 9
  function automatic logic [7:0] rand_digit();
    case ($urandom_range(4))
      0:       return Ch0;
      1:       return Ch9;
      default: return Ch0 + 8'($urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] rand_unit();
    return Ch1 + 8'($urandom_range(NumLeds - 1));
  endfunction

  // Append one complete command with random content
  function automatic void add_command();
    int unsigned k;
    k = $urandom_range(8);
    case (k)
      0, 1: begin
        cmd_bytes.push_back(ChL);
        cmd_bytes.push_back(k == 0 ? ChS : ChC);
        cmd_bytes.push_back(rand_unit());
      end
      2: begin
        cmd_bytes.push_back(ChS);
        cmd_bytes.push_back(rand_unit());
      end
      3, 4, 5: begin
        cmd_bytes.push_back(k == 3 ? ChB : (k == 4 ? ChH : ChC));
        repeat (3) cmd_bytes.push_back(rand_digit());
      end
      default: begin
        cmd_bytes.push_back(k == 6 ? ChP : (k == 7 ? ChI : ChD));
        repeat (4) cmd_bytes.push_back(rand_digit());
      end
    endcase
  endfunction

  // Mostly whole commands, some cut short by a random byte, some pure noise
  task automatic run_phase(input int unsigned items);
    int unsigned goal;
    int unsigned cut;
    int unsigned pick;
    goal = bytes_sent + items;
    while (bytes_sent < goal) begin
      pick = $urandom_range(99);
      cmd_bytes.delete();
      if (pick < 80) begin
        add_command();
      end else if (pick < 92) begin
        add_command();
        cut = $urandom_range(cmd_bytes.size() - 1, 1);
        cmd_bytes = cmd_bytes[0:cut-1];
        cmd_bytes.push_back(8'($urandom_range(255)));
      end else begin
        cmd_bytes.push_back(8'($urandom_range(255)));
      end
      send_all();
    end
  endtask

  // Reply side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: max LED, all-nine arguments, silent drop after L, bad unit, bad digit,
    // byte extremes at idle, LED clear, switch closed and open
    cmd_bytes = '{ChL, ChS, Ch0 + 8'd4, ChB, Ch9, Ch9, Ch9, ChP, Ch9, Ch9, Ch9, Ch9,
                  ChL, 8'h51, ChL, ChS, 8'h35, ChH, Ch1, 8'h78, 8'h00, 8'hFF,
                  ChL, ChC, Ch0 + 8'd4};
    send_all();
    send_byte(ChS, 4'hF);
    send_byte(Ch1, 4'hF);
    send_byte(ChS, 4'h7);
    send_byte(Ch0 + 8'd4, 4'h7);

    // Back-to-back with a long output hold-off to fill the run queue
    hold_req = 1'b1;
    run_phase(55);
    send_idle_pct = 79;
    run_phase(55);
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    run_phase(55);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    run_phase(65);
    s_valid <= 1'b0;

    // Drain the remaining replies, then allow for stragglers
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

/* ascii_command_interpreter.f */
rtl/aci_pkg.sv
rtl/aci_parser.sv
rtl/aci_fifo.sv
rtl/aci_emitter.sv
rtl/ascii_command_interpreter.sv
rtl/aci_checker.sv
tb/aci_reply_checker.sv
tb/ascii_command_interpreter_test.sv
